>>> rtl/ldd_pkg.sv
// ----------------------------------------------------------------------------
// ldd_pkg
// Shared types, register indexes and reset values for the light-mode
// dither DAC controller.
// ----------------------------------------------------------------------------
package ldd_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned CODE_W      = 8;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned IND_W       = 4;

    typedef enum logic [MODE_W-1:0] {
        LIGHT_OFF    = 2'd0,
        LIGHT_DIM    = 2'd1,
        LIGHT_MEDIUM = 2'd2,
        LIGHT_BRIGHT = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEBOUNCE_TICKS      = 3'd0,
        REG_DITHER_PERIOD_TICKS = 3'd1,
        REG_LOW_BASE_CODE       = 3'd2,
        REG_LOW_FRACTION        = 3'd3,
        REG_MEDIUM_CODE         = 3'd4,
        REG_HIGH_CODE           = 3'd5,
        REG_OFF_CODE            = 3'd6
    } cfg_index_t;

    localparam logic [COUNT_W-1:0] DEBOUNCE_TICKS_RST      = 16'd5000;
    localparam logic [COUNT_W-1:0] DITHER_PERIOD_TICKS_RST = 16'd20;
    localparam logic [CODE_W-1:0]  LOW_BASE_CODE_RST       = 8'd170;
    localparam logic [CODE_W-1:0]  LOW_FRACTION_RST        = 8'd154;
    localparam logic [CODE_W-1:0]  MEDIUM_CODE_RST         = 8'd168;
    localparam logic [CODE_W-1:0]  HIGH_CODE_RST           = 8'd165;
    localparam logic [CODE_W-1:0]  OFF_CODE_RST            = 8'd255;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

>>> rtl/ldd_if.sv
// ----------------------------------------------------------------------------
// ldd_if
// Request channels of the light-mode controller: tick requests in,
// status requests out.
// ----------------------------------------------------------------------------
interface ldd_in_if;
    logic valid;
    logic ready;
    logic button_level;
    logic sideband_one;
    logic sideband_two;

    modport source (output valid, output button_level, output sideband_one,
                    output sideband_two, input ready);
    modport sink   (input valid, input button_level, input sideband_one,
                    input sideband_two, output ready);
endinterface

interface ldd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [3:0] indicator_bits;
    logic [7:0] dac_code;
    logic       driver_shutdown;

    modport source (output valid, output mode, output indicator_bits,
                    output dac_code, output driver_shutdown, input ready);
    modport sink   (input valid, input mode, input indicator_bits,
                    input dac_code, input driver_shutdown, output ready);
endinterface

>>> rtl/light_mode_dither_dac_controller.sv
// ----------------------------------------------------------------------------
// light_mode_dither_dac_controller
// Debounced mode button, four-state mode, dithered current-set DAC code.
// ----------------------------------------------------------------------------
// Path: an accepted tick request is held in the input register, then its status request in the status register.
// Throughput: one tick request per cycle; the input register and the status
// register each advance whenever the status register is empty or taken.
// Reset: all control state, mode, counters and config registers return to
// their defaults asynchronously on rst_n low.
module light_mode_dither_dac_controller
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ldd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ldd_pkg::CFG_DATA_W-1:0]    cfg_data,
    ldd_in_if.sink                            tick,
    ldd_out_if.source                         status
);
    import ldd_pkg::*;

    logic [COUNT_W-1:0] debounce_ticks_reg;
    logic [COUNT_W-1:0] dither_period_ticks_reg;
    logic [CODE_W-1:0]  low_base_code_reg;
    logic [CODE_W-1:0]  low_fraction_reg;
    logic [CODE_W-1:0]  medium_code_reg;
    logic [CODE_W-1:0]  high_code_reg;
    logic [CODE_W-1:0]  off_code_reg;

    logic               in_valid_reg;
    logic               in_button_reg;
    logic               in_sb_one_reg;
    logic               in_sb_two_reg;

    logic               out_valid_reg;
    logic [MODE_W-1:0]  out_mode_reg;
    logic [IND_W-1:0]   out_ind_reg;
    logic [CODE_W-1:0]  out_dac_reg;
    logic               out_shutdown_reg;

    mode_t              mode_reg;
    mode_t              mode_next;
    logic               last_level_reg;
    logic               settled_level_reg;
    logic               settled_level_next;
    logic [COUNT_W-1:0] stable_count_reg;
    logic [COUNT_W-1:0] stable_count_next;
    logic [COUNT_W-1:0] dither_elapsed_reg;
    logic [COUNT_W-1:0] dither_elapsed_next;
    logic [CODE_W-1:0]  dither_acc_reg;
    logic [CODE_W-1:0]  dither_acc_next;
    logic [CODE_W-1:0]  dac_hold_reg;
    logic [CODE_W-1:0]  dac_hold_next;

    logic               advance;
    logic               step;
    logic               settle;
    logic [COUNT_W-1:0] elapsed_inc;
    logic [CODE_W:0]    dither_sum;

    assign advance      = !out_valid_reg || status.ready;
    assign step         = in_valid_reg && advance;
    assign tick.ready   = !in_valid_reg || advance;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg      <= DEBOUNCE_TICKS_RST;
            dither_period_ticks_reg <= DITHER_PERIOD_TICKS_RST;
            low_base_code_reg       <= LOW_BASE_CODE_RST;
            low_fraction_reg        <= LOW_FRACTION_RST;
            medium_code_reg         <= MEDIUM_CODE_RST;
            high_code_reg           <= HIGH_CODE_RST;
            off_code_reg            <= OFF_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE_TICKS:      debounce_ticks_reg      <= cfg_data;
                REG_DITHER_PERIOD_TICKS: dither_period_ticks_reg <= cfg_data;
                REG_LOW_BASE_CODE:       low_base_code_reg <= cfg_data[CODE_W-1:0];
                REG_LOW_FRACTION:        low_fraction_reg  <= cfg_data[CODE_W-1:0];
                REG_MEDIUM_CODE:         medium_code_reg   <= cfg_data[CODE_W-1:0];
                REG_HIGH_CODE:           high_code_reg     <= cfg_data[CODE_W-1:0];
                REG_OFF_CODE:            off_code_reg      <= cfg_data[CODE_W-1:0];
                default:                 ;
            endcase
        end
    end

    // debounce and mode next state
    always_comb
    begin
        if (in_button_reg != last_level_reg)
        begin
            stable_count_next = '0;
        end
        else if (stable_count_reg != COUNT_MAX)
        begin
            stable_count_next = stable_count_reg + 1'b1;
        end
        else
        begin
            stable_count_next = stable_count_reg;
        end

        settle = (stable_count_next > debounce_ticks_reg)
              && (in_button_reg != settled_level_reg);
        settled_level_next = settle ? in_button_reg : settled_level_reg;

        if (settle && !in_button_reg)
        begin
            mode_next = mode_t'(mode_reg + 2'd1);
        end
        else
        begin
            mode_next = mode_reg;
        end
    end

    // DAC code and dither
    always_comb
    begin
        elapsed_inc = (dither_elapsed_reg != COUNT_MAX)
                    ? dither_elapsed_reg + 1'b1 : dither_elapsed_reg;
        dither_sum  = {1'b0, dither_acc_reg} + {1'b0, low_fraction_reg};

        dither_elapsed_next = elapsed_inc;
        dither_acc_next     = dither_acc_reg;
        dac_hold_next       = dac_hold_reg;

        unique case (mode_next)
            LIGHT_OFF:    dac_hold_next = off_code_reg;
            LIGHT_MEDIUM: dac_hold_next = medium_code_reg;
            LIGHT_BRIGHT: dac_hold_next = high_code_reg;
            LIGHT_DIM:
            begin
                if (elapsed_inc >= dither_period_ticks_reg)
                begin
                    dither_elapsed_next = '0;
                    priority if (low_fraction_reg == '0)
                    begin
                        dither_acc_next = '0;
                        dac_hold_next   = low_base_code_reg;
                    end
                    else if (dither_sum[CODE_W])
                    begin
                        dither_acc_next = dither_sum[CODE_W-1:0];
                        dac_hold_next   = low_base_code_reg + 1'b1;
                    end
                    else
                    begin
                        dither_acc_next = dither_sum[CODE_W-1:0];
                        dac_hold_next   = low_base_code_reg;
                    end
                end
            end
            default:      dac_hold_next = dac_hold_reg;
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            in_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            in_button_reg <= tick.button_level;
            in_sb_one_reg <= tick.sideband_one;
            in_sb_two_reg <= tick.sideband_two;
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= LIGHT_OFF;
            last_level_reg     <= 1'b1;
            settled_level_reg  <= 1'b1;
            stable_count_reg   <= '0;
            dither_elapsed_reg <= '0;
            dither_acc_reg     <= '0;
            dac_hold_reg       <= '0;
        end
        else if (step)
        begin
            mode_reg           <= mode_next;
            last_level_reg     <= in_button_reg;
            settled_level_reg  <= settled_level_next;
            stable_count_reg   <= stable_count_next;
            dither_elapsed_reg <= dither_elapsed_next;
            dither_acc_reg     <= dither_acc_next;
            dac_hold_reg       <= dac_hold_next;
        end
    end

    // status register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_mode_reg     <= mode_next;
            out_ind_reg      <= IND_W'(1) << mode_next;
            out_dac_reg      <= dac_hold_next;
            out_shutdown_reg <= (in_sb_one_reg && in_sb_two_reg)
                             || (mode_next == LIGHT_OFF);
        end
    end

    assign status.valid           = out_valid_reg;
    assign status.mode            = out_mode_reg;
    assign status.indicator_bits  = out_ind_reg;
    assign status.dac_code        = out_dac_reg;
    assign status.driver_shutdown = out_shutdown_reg;

endmodule
